// File: rtl/core/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants of the priority interrupt controller
// Event codes, init sequence steps, command fields and the priority encoder.
// ----------------------------------------------------------------------------
package pic_pkg;

   typedef enum logic [2:0] {
      OP_READ  = 3'd0,
      OP_WRITE = 3'd1,
      OP_RAISE = 3'd2,
      OP_CLEAR = 3'd3,
      OP_ACK   = 3'd4,
      OP_RESET = 3'd5
   } op_type;

   // Init word sequence; STEP_DONE means the block is initialized.
   typedef enum logic [2:0] {
      STEP_IDLE = 3'd0,
      STEP_ICW2 = 3'd1,
      STEP_ICW3 = 3'd2,
      STEP_ICW4 = 3'd3,
      STEP_DONE = 3'd4
   } init_step_type;

   // Command byte bit positions
   localparam int unsigned ICW1_BIT          = 4;   // init word 1 on the command port
   localparam int unsigned OCW3_BIT          = 3;   // read-select command, else EOI
   localparam int unsigned OCW3_RR_BIT       = 1;   // read-select enable
   localparam int unsigned OCW3_RIS_BIT      = 0;   // 1 selects ISR readback
   localparam int unsigned ICW1_LEVEL_BIT    = 3;   // level mode
   localparam int unsigned ICW1_SINGLE_BIT   = 1;   // no ICW3
   localparam int unsigned ICW1_IC4          = 0;   // ICW4 follows
   localparam int unsigned ICW4_AUTO_EOI_BIT = 1;   // auto end of interrupt

   // EOI codes in command bits 7:5
   localparam logic [2:0] EOI_NON_SPECIFIC = 3'b001;
   localparam logic [2:0] EOI_SPECIFIC     = 3'b011;

   typedef struct packed {
      op_type     op;
      logic       port_sel;
      logic [7:0] data_in;
      logic [2:0] irq_line;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       got_interrupt;
      logic [7:0] vector;
      logic       intr_raise;
      logic       intr_drop;
   } rsp_item_type;

   typedef struct packed {
      logic       found;
      logic [2:0] line;
   } pri_type;

   // Lowest set bit wins (line 0 is highest priority).
   function automatic pri_type lowest_set(input logic [7:0] bits);
      pri_type res;
      res.found = 1'b0;
      res.line  = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (bits[i]) begin
            res.found = 1'b1;
            res.line  = 3'(i);
         end
      end
      return res;
   endfunction

endpackage

// File: rtl/core/pic_channels.sv
// ----------------------------------------------------------------------------
// pic_channels: valid/ready channels of the priority interrupt controller
// Event channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface pic_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic       port_sel;
   logic [7:0] data_in;
   logic [2:0] irq_line;

   modport source (output valid, op, port_sel, data_in, irq_line, input ready);
   modport sink   (input valid, op, port_sel, data_in, irq_line, output ready);
endinterface

interface pic_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       got_interrupt;
   logic [7:0] vector;
   logic       intr_raise;
   logic       intr_drop;

   modport source (output valid, read_data, got_interrupt, vector, intr_raise, intr_drop,
                   input ready);
   modport sink   (input valid, read_data, got_interrupt, vector, intr_raise, intr_drop,
                   output ready);
endinterface

// File: rtl/core/pic_in_stage.sv
// ----------------------------------------------------------------------------
// pic_in_stage: event input register
// Holds one accepted event until the core consumes it.
// ----------------------------------------------------------------------------
module pic_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pic_pkg::req_item_type in_item,
   input  logic                  consume,
   output logic                  item_valid,
   output pic_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   pic_pkg::req_item_type item_ff;

   assign in_ready   = !valid_ff || consume;
   assign valid_in   = in_valid || (valid_ff && !consume);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ready ? in_valid : valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// File: rtl/core/pic_core.sv
// ----------------------------------------------------------------------------
// pic_core: controller state and per-event update
// Request, in-service and mask registers, init sequence, result build.
// ----------------------------------------------------------------------------
module pic_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  pic_pkg::req_item_type item,
   output pic_pkg::rsp_item_type result
);

   logic [7:0]             mask_ff, mask_in;
   logic [7:0]             request_ff, request_in;
   logic [7:0]             service_ff, service_in;
   logic                   isr_sel_ff, isr_sel_in;
   logic                   level_ff, level_in;
   logic                   single_ff, single_in;
   logic                   ic4_ff, ic4_in;
   logic [4:0]             icw2_ff, icw2_in;
   logic                   aeoi_ff, aeoi_in;
   pic_pkg::init_step_type step_ff, step_in;

   logic                   done;
   logic                   is_icw1;
   logic [7:0]             line_bit;
   logic [7:0]             pend;
   pic_pkg::pri_type       pend_pri;
   pic_pkg::pri_type       svc_pri;
   logic [7:0]             pend_bit;
   logic [7:0]             svc_bit;
   logic [7:0]             eoi_bit;

   assign done     = (step_ff == pic_pkg::STEP_DONE);
   assign is_icw1  = item.data_in[pic_pkg::ICW1_BIT];
   assign line_bit = 8'h01 << item.irq_line;
   assign pend     = request_ff & ~mask_ff & ~service_ff;
   assign pend_pri = pic_pkg::lowest_set(pend);
   assign svc_pri  = pic_pkg::lowest_set(service_ff);
   assign pend_bit = 8'h01 << pend_pri.line;
   assign svc_bit  = svc_pri.found ? (8'h01 << svc_pri.line) : 8'h00;
   assign eoi_bit  = 8'h01 << item.data_in[2:0];

   // Init sequence step
   always_comb begin
      step_in = step_ff;
      if (fire) begin
         unique case (item.op)
            pic_pkg::OP_RESET: step_in = pic_pkg::STEP_IDLE;
            pic_pkg::OP_WRITE: begin
               if (!item.port_sel) begin
                  if (is_icw1) step_in = pic_pkg::STEP_ICW2;
               end else begin
                  unique case (step_ff)
                     pic_pkg::STEP_ICW2: begin
                        if (!single_ff) step_in = pic_pkg::STEP_ICW3;
                        else if (ic4_ff) step_in = pic_pkg::STEP_ICW4;
                        else step_in = pic_pkg::STEP_DONE;
                     end
                     pic_pkg::STEP_ICW3:
                        step_in = ic4_ff ? pic_pkg::STEP_ICW4 : pic_pkg::STEP_DONE;
                     pic_pkg::STEP_ICW4: step_in = pic_pkg::STEP_DONE;
                     default: step_in = step_ff;
                  endcase
               end
            end
            default: step_in = step_ff;
         endcase
      end
   end

   // Register updates and result
   always_comb begin
      mask_in    = mask_ff;
      request_in = request_ff;
      service_in = service_ff;
      isr_sel_in = isr_sel_ff;
      level_in   = level_ff;
      single_in  = single_ff;
      ic4_in     = ic4_ff;
      icw2_in    = icw2_ff;
      aeoi_in    = aeoi_ff;
      result     = '0;
      unique case (item.op)
         pic_pkg::OP_READ: begin
            if (item.port_sel) result.read_data = mask_ff;
            else result.read_data = isr_sel_ff ? service_ff : request_ff;
         end
         pic_pkg::OP_WRITE: begin
            if (item.port_sel) begin
               if (done) begin
                  mask_in = item.data_in;
               end else begin
                  case (step_ff)
                     pic_pkg::STEP_ICW2: icw2_in = item.data_in[7:3];
                     pic_pkg::STEP_ICW4:
                        aeoi_in = item.data_in[pic_pkg::ICW4_AUTO_EOI_BIT];
                     default: ;
                  endcase
               end
            end else if (is_icw1) begin
               result.intr_drop = 1'b1;
               mask_in    = '0;
               request_in = '0;
               service_in = '0;
               isr_sel_in = 1'b0;
               icw2_in    = '0;
               aeoi_in    = 1'b0;
               level_in   = item.data_in[pic_pkg::ICW1_LEVEL_BIT];
               single_in  = item.data_in[pic_pkg::ICW1_SINGLE_BIT];
               ic4_in     = item.data_in[pic_pkg::ICW1_IC4];
            end else if (done) begin
               if (!item.data_in[pic_pkg::OCW3_BIT]) begin
                  case (item.data_in[7:5])
                     pic_pkg::EOI_NON_SPECIFIC: service_in = service_ff & ~svc_bit;
                     pic_pkg::EOI_SPECIFIC:     service_in = service_ff & ~eoi_bit;
                     default: ;
                  endcase
               end else if (item.data_in[pic_pkg::OCW3_RR_BIT]) begin
                  isr_sel_in = item.data_in[pic_pkg::OCW3_RIS_BIT];
               end
            end
         end
         pic_pkg::OP_RAISE: begin
            if (done && ((service_ff | request_ff | mask_ff) & line_bit) == 8'h00) begin
               request_in = request_ff | line_bit;
            end
         end
         pic_pkg::OP_CLEAR: begin
            if (done) begin
               result.intr_drop = svc_pri.found && (svc_pri.line == item.irq_line);
               request_in = request_ff & ~line_bit;
               service_in = service_ff & ~line_bit;
            end
         end
         pic_pkg::OP_ACK: begin
            if (done && pend_pri.found) begin
               if (!aeoi_ff) service_in = service_ff | pend_bit;
               if (!level_ff) request_in = request_ff & ~pend_bit;
               result.got_interrupt = 1'b1;
               result.intr_raise    = 1'b1;
               result.vector        = {icw2_ff, pend_pri.line};
            end
         end
         pic_pkg::OP_RESET: begin
            mask_in    = '0;
            request_in = '0;
            service_in = '0;
            isr_sel_in = 1'b0;
            level_in   = 1'b0;
            single_in  = 1'b0;
            ic4_in     = 1'b0;
            icw2_in    = '0;
            aeoi_in    = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= '0;
         request_ff <= '0;
         service_ff <= '0;
         isr_sel_ff <= 1'b0;
         level_ff   <= 1'b0;
         single_ff  <= 1'b0;
         ic4_ff     <= 1'b0;
         icw2_ff    <= '0;
         aeoi_ff    <= 1'b0;
         step_ff    <= pic_pkg::STEP_IDLE;
      end else if (fire) begin
         mask_ff    <= mask_in;
         request_ff <= request_in;
         service_ff <= service_in;
         isr_sel_ff <= isr_sel_in;
         level_ff   <= level_in;
         single_ff  <= single_in;
         ic4_ff     <= ic4_in;
         icw2_ff    <= icw2_in;
         aeoi_ff    <= aeoi_in;
         step_ff    <= step_in;
      end
   end

endmodule

// File: rtl/core/pic_out_stage.sv
// ----------------------------------------------------------------------------
// pic_out_stage: result register
// Holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module pic_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  pic_pkg::rsp_item_type load_item,
   output logic                  can_load,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pic_pkg::rsp_item_type out_item
);

   logic                  valid_ff;
   pic_pkg::rsp_item_type item_ff;

   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && can_load) begin
         item_ff <= load_item;
      end
   end

endmodule

// File: rtl/core/priority_interrupt_controller.sv
// ----------------------------------------------------------------------------
// priority_interrupt_controller: eight-line priority interrupt controller
// Path: an event passes the input register, then the result register, and leaves
//   from there when the sink is ready; each event yields exactly one result.
// Throughput: one event per cycle, limited only by the result sink's ready.
// Reset: synchronous; clears both pipeline stages and all controller state.
// ----------------------------------------------------------------------------
module priority_interrupt_controller (
   input  logic      clock,
   input  logic      reset,
   pic_req_if.sink   req_chan,
   pic_rsp_if.source rsp_chan
);

   pic_pkg::req_item_type in_item;
   pic_pkg::req_item_type item;
   pic_pkg::rsp_item_type result;
   pic_pkg::rsp_item_type out_item;
   logic                  item_valid;
   logic                  can_load;
   logic                  fire;

   // Pack the input transfer payload.
   assign in_item.op       = pic_pkg::op_type'(req_chan.op);
   assign in_item.port_sel = req_chan.port_sel;
   assign in_item.data_in  = req_chan.data_in;
   assign in_item.irq_line = req_chan.irq_line;

   // The held event is processed in the cycle it moves into the result register.
   assign fire = item_valid && can_load;

   pic_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_item    (in_item),
      .consume    (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   // State registers update only on fire, so events are applied in order.
   pic_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   pic_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (item_valid),
      .load_item (result),
      .can_load  (can_load),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   assign rsp_chan.read_data     = out_item.read_data;
   assign rsp_chan.got_interrupt = out_item.got_interrupt;
   assign rsp_chan.vector        = out_item.vector;
   assign rsp_chan.intr_raise    = out_item.intr_raise;
   assign rsp_chan.intr_drop     = out_item.intr_drop;

`ifndef NO_ASSERTIONS
   // Both stages full and the sink stalled: no new transfer may be taken.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (item_valid && rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input accepted while pipeline is full");

   // A result register load comes only from a held event.
   a_load_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !$past(rsp_chan.valid)) |-> $past(item_valid))
      else $error("result appeared without an event");

   // Raise flag mirrors the acknowledge flag.
   a_raise_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.intr_raise == rsp_chan.got_interrupt))
      else $error("intr_raise differs from got_interrupt");

   // Vector and read data are zero outside their own events.
   a_vector_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.got_interrupt) |-> (rsp_chan.vector == 8'h00))
      else $error("vector set without an interrupt");

   a_ack_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.got_interrupt) |->
         (rsp_chan.read_data == 8'h00 && !rsp_chan.intr_drop))
      else $error("acknowledge result carries read or drop data");
`endif

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: regression bench for the priority interrupt controller
// Drives bus, line and acknowledge events, predicts each result with an in-bench
// copy of the controller state or takes it from a GOLDEN directed row, and checks each result in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pic_pkg::*;

   localparam int unsigned HALF_PERIOD  = 6;
   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned IDLE_PCT     = 15;
   localparam int unsigned RANDOM_ITEMS = 500;
   localparam int unsigned QUIET_SPAN   = 120;   // events in the stretch with no idling
   localparam int unsigned QUIET_INDEX  = 2;     // which session runs without idling
   localparam int unsigned DRAIN_CYCLES = 10;    // input and result registers, with margin
   localparam int unsigned STUCK_LIMIT  = 2000;  // cycles with no transfer at all

   // Where a row's expected result comes from.
   localparam bit MODEL  = 1'b0;
   localparam bit GOLDEN = 1'b1;

   typedef struct {
      req_item_type ev;
      bit           typed;
      rsp_item_type answer;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   pic_req_if req_chan ();
   pic_rsp_if rsp_chan ();

   priority_interrupt_controller u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #HALF_PERIOD clock = ~clock;

   // --------------------------------------------------------------------------
   // Controller state as the bench sees it
   // --------------------------------------------------------------------------
   logic [7:0]    ctl_mask;
   logic [7:0]    ctl_irr;
   logic [7:0]    ctl_isr;
   logic          ctl_read_isr;
   logic [7:0]    ctl_icw [4];
   logic          ctl_init_done;
   init_step_type ctl_step;

   stim_row_type  directed_rows [$];
   stim_row_type  typed_answers [$];   // one per driven event, popped on its transfer
   rsp_item_type  awaited_results [$];

   int unsigned   req_idle_pct  = IDLE_PCT;
   int unsigned   rsp_stall_pct = IDLE_PCT;
   int unsigned   random_sent;
   int unsigned   mismatch_count;
   int unsigned   stuck_cycles;

   // Scratch for the monitors
   req_item_type  taken_event;
   rsp_item_type  predicted_result;
   rsp_item_type  result_want;
   stim_row_type  row_now;

   task automatic clear_controller();
      ctl_mask      = '0;
      ctl_irr       = '0;
      ctl_isr       = '0;
      ctl_read_isr  = 1'b0;
      ctl_icw       = '{default: 8'h00};
      ctl_init_done = 1'b0;
      ctl_step      = STEP_IDLE;
   endtask

   // 8 when nothing is set; line 0 wins.
   function automatic int unsigned lowest_bit(input logic [7:0] bits);
      for (int i = 0; i < 8; i++)
         if (bits[i]) return i;
      return 8;
   endfunction

   // Data port: init words until the sequence is done, then the mask.
   task automatic data_port_write(input logic [7:0] v);
      if (ctl_init_done) begin
         ctl_mask = v;
         return;
      end
      case (ctl_step)
         STEP_ICW2: begin
            ctl_icw[1] = v & 8'hF8;
            ctl_step   = STEP_ICW3;
            if (ctl_icw[0][ICW1_SINGLE_BIT]) begin
               ctl_step = ctl_icw[0][ICW1_IC4] ? STEP_ICW4 : STEP_DONE;
            end
         end
         STEP_ICW3: begin
            ctl_icw[2] = v;
            ctl_step   = ctl_icw[0][ICW1_IC4] ? STEP_ICW4 : STEP_DONE;
         end
         STEP_ICW4: begin
            ctl_icw[3] = v;
            ctl_step   = STEP_DONE;
         end
         default: ;
      endcase
      if (ctl_step == STEP_DONE) ctl_init_done = 1'b1;
   endtask

   // Command port: ICW1 anytime, EOI and read select once initialized.
   task automatic command_port_write(input logic [7:0] v, inout rsp_item_type res);
      int unsigned l;
      if (v[ICW1_BIT]) begin
         res.intr_drop = 1'b1;
         clear_controller();
         ctl_icw[0] = v;
         ctl_step   = STEP_ICW2;
         return;
      end
      if (!ctl_init_done) return;
      if (!v[OCW3_BIT]) begin
         if (v[7:5] == EOI_NON_SPECIFIC) begin
            l = lowest_bit(ctl_isr);
            if (l < 8) ctl_isr[l] = 1'b0;
         end else if (v[7:5] == EOI_SPECIFIC) begin
            ctl_isr[v[2:0]] = 1'b0;
         end
      end else if (v[OCW3_RR_BIT]) begin
         ctl_read_isr = v[OCW3_RIS_BIT];
      end
   endtask

   // One event in, one result out; updates the bench copy of the state.
   task automatic controller_step(input req_item_type ev, output rsp_item_type res);
      int unsigned l;
      logic [7:0]  pend;
      res = '0;
      case (ev.op)
         OP_READ: begin
            if (ev.port_sel) res.read_data = ctl_mask;
            else             res.read_data = ctl_read_isr ? ctl_isr : ctl_irr;
         end
         OP_WRITE: begin
            if (ev.port_sel) data_port_write(ev.data_in);
            else             command_port_write(ev.data_in, res);
         end
         OP_RAISE: begin
            if (ctl_init_done && !ctl_isr[ev.irq_line] && !ctl_mask[ev.irq_line])
               ctl_irr[ev.irq_line] = 1'b1;
         end
         OP_CLEAR: begin
            if (ctl_init_done) begin
               if (lowest_bit(ctl_isr) == ev.irq_line) res.intr_drop = 1'b1;
               ctl_irr[ev.irq_line] = 1'b0;
               ctl_isr[ev.irq_line] = 1'b0;
            end
         end
         OP_ACK: begin
            if (ctl_init_done) begin
               pend = ctl_irr & ~ctl_mask & ~ctl_isr;
               l    = lowest_bit(pend);
               if (l < 8) begin
                  if (!ctl_icw[3][ICW4_AUTO_EOI_BIT]) ctl_isr[l] = 1'b1;
                  if (!ctl_icw[0][ICW1_LEVEL_BIT]) ctl_irr[l] = 1'b0;
                  res.got_interrupt = 1'b1;
                  res.vector        = ctl_icw[1] | 8'(l);
                  res.intr_raise    = 1'b1;
               end
            end
         end
         OP_RESET: clear_controller();
         default: ;
      endcase
   endtask

   // --------------------------------------------------------------------------
   // Event side: one item per call, random idle cycles ahead of it.
   // Entered and left at a falling edge.
   // --------------------------------------------------------------------------
   task automatic send_item(input stim_row_type row);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      typed_answers.push_back(row);
      req_chan.valid    <= 1'b1;
      req_chan.op       <= row.ev.op;
      req_chan.port_sel <= row.ev.port_sel;
      req_chan.data_in  <= row.ev.data_in;
      req_chan.irq_line <= row.ev.irq_line;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_op(input op_type op, input logic port, input logic [7:0] data,
                          input logic [2:0] line);
      stim_row_type row;
      row.ev       = '{op: op, port_sel: port, data_in: data, irq_line: line};
      row.typed    = MODEL;
      row.answer   = '0;
      random_sent++;
      send_item(row);
   endtask

   // Directed table entry; the answer fields only count for GOLDEN rows.
   task automatic add_row(input op_type op, input logic port, input logic [7:0] data,
                          input logic [2:0] line, input bit typed, input logic [7:0] rd,
                          input logic got, input logic [7:0] vec, input logic drop);
      stim_row_type row;
      row.ev     = '{op: op, port_sel: port, data_in: data, irq_line: line};
      row.typed  = typed;
      row.answer = '{read_data: rd, got_interrupt: got, vector: vec,
                     intr_raise: got, intr_drop: drop};
      directed_rows.push_back(row);
   endtask

   task automatic build_directed_rows();
      //       op         port  data   line  source  rd     got   vec    drop
      // untouched block: reads give zero, writes and line events are dropped
      add_row(OP_READ,  1'b0, 8'h00, 3'd0, GOLDEN, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_WRITE, 1'b1, 8'hFF, 3'd0, GOLDEN, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_RAISE, 1'b0, 8'h00, 3'd0, GOLDEN, 8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_ACK,   1'b0, 8'h00, 3'd0, GOLDEN, 8'h00, 1'b0, 8'h00, 1'b0);
      // full init: edge mode, ICW3 and ICW4 both follow, ICW2 top bits all set
      add_row(OP_WRITE, 1'b0, 8'h11, 3'd0, GOLDEN, 8'h00, 1'b0, 8'h00, 1'b1);
      add_row(OP_WRITE, 1'b1, 8'hFF, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_WRITE, 1'b1, 8'h00, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_WRITE, 1'b1, 8'h00, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      // lowest and highest line pending; line 0 wins the acknowledge
      add_row(OP_RAISE, 1'b0, 8'h00, 3'd7, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_RAISE, 1'b0, 8'h00, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_ACK,   1'b0, 8'h00, 3'd0, GOLDEN, 8'h00, 1'b1, 8'hF8, 1'b0);
      add_row(OP_READ,  1'b0, 8'h00, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      // switch readback to the in-service register
      add_row(OP_WRITE, 1'b0, 8'h0B, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_READ,  1'b0, 8'h00, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      // everything masked: acknowledge finds nothing
      add_row(OP_WRITE, 1'b1, 8'hFF, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_READ,  1'b1, 8'h00, 3'd0, GOLDEN, 8'hFF, 1'b0, 8'h00, 1'b0);
      add_row(OP_ACK,   1'b0, 8'h00, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_WRITE, 1'b1, 8'h00, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      // clearing the top in-service line drops the output
      add_row(OP_CLEAR, 1'b0, 8'h00, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_ACK,   1'b0, 8'h00, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_WRITE, 1'b0, 8'h20, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      // short init: level mode, single, no ICW4, so done after ICW2
      add_row(OP_WRITE, 1'b0, 8'h1A, 3'd0, GOLDEN, 8'h00, 1'b0, 8'h00, 1'b1);
      add_row(OP_WRITE, 1'b1, 8'h47, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_RAISE, 1'b0, 8'h00, 3'd3, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_ACK,   1'b0, 8'h00, 3'd0, MODEL,  8'h00, 1'b0, 8'h00, 1'b0);
      add_row(OP_RESET, 1'b0, 8'h00, 3'd0, GOLDEN, 8'h00, 1'b0, 8'h00, 1'b0);
   endtask

   // Mostly well-formed traffic: EOI and read-select codes, sparse masks.
   task automatic send_random_event();
      int unsigned pick;
      logic [7:0]  cmd;
      pick = $urandom_range(99);
      cmd  = 8'($urandom);
      if (pick < 28) begin
         send_op(OP_RAISE, 1'($urandom), cmd, 3'($urandom));
      end else if (pick < 46) begin
         send_op(OP_ACK, 1'($urandom), cmd, 3'($urandom));
      end else if (pick < 54) begin
         send_op(OP_CLEAR, 1'($urandom), cmd, 3'($urandom));
      end else if (pick < 66) begin
         send_op(OP_READ, 1'($urandom), cmd, 3'($urandom));
      end else if (pick < 76) begin
         cmd[ICW1_BIT] = 1'b0;
         cmd[OCW3_BIT] = 1'b0;
         case ($urandom_range(2))
            0: cmd[7:5] = EOI_NON_SPECIFIC;
            1: cmd[7:5] = EOI_SPECIFIC;
            default: ;   // rotation / set-priority codes, ignored by the block
         endcase
         send_op(OP_WRITE, 1'b0, cmd, 3'($urandom));
      end else if (pick < 83) begin
         cmd[ICW1_BIT] = 1'b0;
         cmd[OCW3_BIT] = 1'b1;
         send_op(OP_WRITE, 1'b0, cmd, 3'($urandom));
      end else if (pick < 88) begin
         send_op(OP_WRITE, 1'b1, cmd & 8'($urandom), 3'($urandom));
      end else if (pick < 92) begin
         // raw noise, may re-init or reset the block mid-session
         send_op(op_type'($urandom_range(OP_RESET)), 1'($urandom), cmd, 3'($urandom));
      end else begin
         send_op(OP_ACK, 1'($urandom), cmd, 3'($urandom));
      end
   endtask

   // Init sequence with random ICW1 flags, then a run of events.
   // A few sessions cut the init short on purpose.
   task automatic run_session(input int unsigned span);
      logic [7:0]  icw1;
      int unsigned words;
      if ($urandom_range(9) == 0)
         send_op(OP_RESET, 1'($urandom), 8'($urandom), 3'($urandom));
      icw1           = 8'($urandom);
      icw1[ICW1_BIT] = 1'b1;
      send_op(OP_WRITE, 1'b0, icw1, 3'($urandom));
      words = 1 + int'(!icw1[ICW1_SINGLE_BIT]) + int'(icw1[ICW1_IC4]);
      if ($urandom_range(9) == 0) words = $urandom_range(words - 1);
      repeat (words) send_op(OP_WRITE, 1'b1, 8'($urandom), 3'($urandom));
      if ($urandom_range(1))
         send_op(OP_WRITE, 1'b1, 8'($urandom) & 8'($urandom), 3'($urandom));
      repeat (span) send_random_event();
   endtask

   // --------------------------------------------------------------------------
   // Result side: random stalls on ready, changed at the falling edge
   // --------------------------------------------------------------------------
   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);

   // Event transfer: run the predictor, queue what the block should answer.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         taken_event.op       = op_type'(req_chan.op);
         taken_event.port_sel = req_chan.port_sel;
         taken_event.data_in  = req_chan.data_in;
         taken_event.irq_line = req_chan.irq_line;
         controller_step(taken_event, predicted_result);
         row_now = typed_answers.pop_front();
         awaited_results.push_back(row_now.typed ? row_now.answer : predicted_result);
      end
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
         mismatch_count++;
      end
   endtask

   // Result transfer: compare against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: result with nothing expected, actual rd=%0h got=%0b vec=%0h",
                     $time, rsp_chan.read_data, rsp_chan.got_interrupt, rsp_chan.vector);
            mismatch_count++;
         end else begin
            result_want = awaited_results.pop_front();
            check_field("read_data", result_want.read_data, rsp_chan.read_data);
            check_field("got_interrupt", 8'(result_want.got_interrupt),
                        8'(rsp_chan.got_interrupt));
            check_field("vector", result_want.vector, rsp_chan.vector);
            check_field("intr_raise", 8'(result_want.intr_raise),
                        8'(rsp_chan.intr_raise));
            check_field("intr_drop", 8'(result_want.intr_drop),
                        8'(rsp_chan.intr_drop));
         end
      end
   end

   // Watchdog: any transfer on either side resets the count.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
         $display("priority_interrupt_controller regression: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      int unsigned session;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.op       = OP_READ;
      req_chan.port_sel = 1'b0;
      req_chan.data_in  = 8'h00;
      req_chan.irq_line = 3'd0;
      rsp_chan.ready    = 1'b0;
      mismatch_count    = 0;
      stuck_cycles      = 0;
      random_sent       = 0;
      clear_controller();
      build_directed_rows();

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);

      // Random sessions; one of them runs with both sides at full rate.
      session     = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         req_idle_pct  = (session == QUIET_INDEX) ? 0 : IDLE_PCT;
         rsp_stall_pct = (session == QUIET_INDEX) ? 0 : IDLE_PCT;
         run_session((session == QUIET_INDEX) ? QUIET_SPAN : $urandom_range(15, 60));
         session++;
      end
      req_idle_pct  = IDLE_PCT;
      rsp_stall_pct = IDLE_PCT;
      req_chan.valid <= 1'b0;

      // Drain, then give a late stray result time to show up.
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("priority_interrupt_controller regression: pass");
      else
         $display("priority_interrupt_controller regression: fail");
      $finish;
   end

endmodule
